[rtl/ttlt_pkg.sv]
`default_nettype none

package ttlt_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Word modes
    localparam logic [1:0] MODE_MEASURE = 2'd0;
    localparam logic [1:0] MODE_TINT    = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_HIGHLIGHT = 2'd0;
    localparam logic [1:0] REG_MIDTONE   = 2'd1;
    localparam logic [1:0] REG_SHADOW    = 2'd2;

    localparam logic [23:0] HIGHLIGHT_RESET = 24'hFFFFFF;
    localparam logic [23:0] MIDTONE_RESET   = 24'h808080;
    localparam logic [23:0] SHADOW_RESET    = 24'h000000;

    // Measure and flat-image thresholds
    localparam logic [7:0] ALPHA_FLOOR = 8'd16;
    localparam logic [7:0] FLAT_SPREAD = 8'd16;

    // BT.601 weights, scaled by 1000, with rounding bias
    localparam logic [17:0] W_RED   = 18'd299;
    localparam logic [17:0] W_GREEN = 18'd587;
    localparam logic [17:0] W_BLUE  = 18'd114;
    localparam logic [17:0] W_ROUND = 18'd500;

    // floor(x / 1000) = (x * ceil(2^28 / 1000)) >> 28, exact for x below 493000
    localparam logic [36:0] LUMA_RECIP = 37'd268436;
    localparam int          LUMA_SHIFT = 28;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_FLAT,
        KIND_RAMP
    } kind_t;

    // One tint job handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] num;
        logic [7:0]  den;
    } job_t;

    typedef struct packed {
        logic [23:0] highlight;
        logic [23:0] midtone;
        logic [23:0] shadow;
    } palette_t;

    // Queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

[rtl/ttlt_front.sv]
`default_nettype none

module ttlt_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [1:0]      mode,
    input  wire logic [7:0]      in_alpha,
    input  wire logic [7:0]      in_red,
    input  wire logic [7:0]      in_green,
    input  wire logic [7:0]      in_blue,
    input  wire logic            q_full,
    output logic                 push,
    output ttlt_pkg::job_t       job
);

    // Stage A: captured word
    logic       a_valid_reg;
    logic [1:0] a_mode_reg;
    logic [7:0] a_alpha_reg, a_red_reg, a_green_reg, a_blue_reg;
    // Stage B: weighted sum
    logic        b_valid_reg;
    logic [1:0]  b_mode_reg;
    logic [7:0]  b_alpha_reg, b_red_reg, b_green_reg, b_blue_reg;
    logic [17:0] b_sum_reg;
    logic [17:0] b_sum_next;
    // Stage C: luma, classify and update statistics
    logic       c_valid_reg;
    logic [1:0] c_mode_reg;
    logic [7:0] c_alpha_reg, c_red_reg, c_green_reg, c_blue_reg;
    logic [7:0] c_luma_reg;
    logic [7:0] c_luma_next;
    logic [36:0] luma_prod;
    // Tone statistics
    logic [7:0] tone_low_reg, tone_high_reg;
    logic       seen_reg;

    logic       advance;
    logic       flat;
    logic [7:0] spread;
    logic [7:0] luma_clamped;
    logic [7:0] delta;

    // Advance the whole front unless a tint word waits on a full queue
    assign advance  = !(c_valid_reg && (c_mode_reg == ttlt_pkg::MODE_TINT) && q_full);
    assign in_stall = !advance;

    // Weighted sum of the channels
    assign b_sum_next = 18'(a_red_reg) * ttlt_pkg::W_RED
                      + 18'(a_green_reg) * ttlt_pkg::W_GREEN
                      + 18'(a_blue_reg) * ttlt_pkg::W_BLUE
                      + ttlt_pkg::W_ROUND;

    // Divide by 1000 through the reciprocal
    assign luma_prod   = 37'(b_sum_reg) * ttlt_pkg::LUMA_RECIP;
    assign c_luma_next = luma_prod[ttlt_pkg::LUMA_SHIFT +: 8];

    // Classify the tint word against the current statistics
    assign spread = tone_high_reg - tone_low_reg;
    assign flat   = !seen_reg || (tone_high_reg < tone_low_reg)
                  || (spread < ttlt_pkg::FLAT_SPREAD);

    always_comb
    begin
        if (c_luma_reg < tone_low_reg)
            luma_clamped = tone_low_reg;
        else if (c_luma_reg > tone_high_reg)
            luma_clamped = tone_high_reg;
        else
            luma_clamped = c_luma_reg;
    end

    assign delta = luma_clamped - tone_low_reg;

    always_comb
    begin
        job.alpha = c_alpha_reg;
        job.red   = c_red_reg;
        job.green = c_green_reg;
        job.blue  = c_blue_reg;
        job.num   = {delta, 8'd0} - 16'(delta);
        job.den   = spread;
        if (c_alpha_reg == 8'd0)
            job.kind = ttlt_pkg::KIND_PASS;
        else if (flat)
            job.kind = ttlt_pkg::KIND_FLAT;
        else
            job.kind = ttlt_pkg::KIND_RAMP;
    end

    assign push = advance && c_valid_reg && (c_mode_reg == ttlt_pkg::MODE_TINT);

    // Hold valid flags and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            tone_low_reg  <= 8'd255;
            tone_high_reg <= 8'd0;
            seen_reg      <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg)
            begin
                if (c_mode_reg == ttlt_pkg::MODE_CLEAR)
                begin
                    tone_low_reg  <= 8'd255;
                    tone_high_reg <= 8'd0;
                    seen_reg      <= 1'b0;
                end
                else if ((c_mode_reg == ttlt_pkg::MODE_MEASURE)
                         && (c_alpha_reg > ttlt_pkg::ALPHA_FLOOR))
                begin
                    if (c_luma_reg < tone_low_reg)
                        tone_low_reg <= c_luma_reg;
                    if (c_luma_reg > tone_high_reg)
                        tone_high_reg <= c_luma_reg;
                    seen_reg <= 1'b1;
                end
            end
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_mode_reg  <= mode;
            a_alpha_reg <= in_alpha;
            a_red_reg   <= in_red;
            a_green_reg <= in_green;
            a_blue_reg  <= in_blue;

            b_mode_reg  <= a_mode_reg;
            b_alpha_reg <= a_alpha_reg;
            b_red_reg   <= a_red_reg;
            b_green_reg <= a_green_reg;
            b_blue_reg  <= a_blue_reg;
            b_sum_reg   <= b_sum_next;

            c_mode_reg  <= b_mode_reg;
            c_alpha_reg <= b_alpha_reg;
            c_red_reg   <= b_red_reg;
            c_green_reg <= b_green_reg;
            c_blue_reg  <= b_blue_reg;
            c_luma_reg  <= c_luma_next;
        end
    end

endmodule

`default_nettype wire

[rtl/ttlt_queue.sv]
`default_nettype none

module ttlt_queue #(
    parameter int DEPTH = ttlt_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ttlt_pkg::job_t        push_job,
    input  wire logic                  pop,
    output ttlt_pkg::job_t             pop_job,
    output ttlt_pkg::queue_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttlt_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

[rtl/ttlt_back.sv]
`default_nettype none

module ttlt_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ttlt_pkg::palette_t   palette,
    input  wire logic                 q_empty,
    input  wire ttlt_pkg::job_t       job,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_alpha,
    output logic [7:0]                out_red,
    output logic [7:0]                out_green,
    output logic [7:0]                out_blue
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BLEND,
        ST_NORM,
        ST_DONE
    } state_t;

    // Rounded blend numerator: lo*(255-amt) + hi*amt + 127
    function automatic logic [15:0] mix_sum(input logic [7:0] lo, input logic [7:0] hi,
                                            input logic [7:0] amt);
        logic [15:0] lo_part, hi_part;
        lo_part = 16'(lo) * 16'(8'd255 - amt);
        hi_part = 16'(hi) * 16'(amt);
        return lo_part + hi_part + 16'd127;
    endfunction

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + 16'(x[15:8]) + 16'd1;
        return t[15:8];
    endfunction

    state_t         state_reg;
    ttlt_pkg::job_t job_reg;
    logic [7:0]     rem_reg, numlo_reg, quo_reg;
    logic [2:0]     cnt_reg;
    logic [15:0]    sum_r_reg, sum_g_reg, sum_b_reg;
    logic [7:0]     res_r_reg, res_g_reg, res_b_reg;
    logic           out_valid_reg;
    logic [7:0]     out_alpha_reg, out_red_reg, out_green_reg, out_blue_reg;

    logic [8:0]     trial;
    logic           qbit;
    logic [7:0]     rem_next;
    logic [7:0]     amt;
    logic [23:0]    lo_col, hi_col;

    // One restoring divide step per cycle
    assign trial    = {rem_reg, numlo_reg[7]};
    assign qbit     = (trial >= {1'b0, job_reg.den});
    assign rem_next = qbit ? 8'(trial - {1'b0, job_reg.den}) : trial[7:0];

    // Pick the ramp half from the index top bit
    assign amt    = {quo_reg[6:0], 1'b0};
    assign lo_col = quo_reg[7] ? palette.midtone : palette.shadow;
    assign hi_col = quo_reg[7] ? palette.highlight : palette.midtone;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_alpha = out_alpha_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

    // Sequence one job and hold the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            // Raise the result word when a job finishes, drop it once taken
            if ((state_reg == ST_DONE) && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        job_reg   <= job;
                        rem_reg   <= job.num[15:8];
                        numlo_reg <= job.num[7:0];
                        cnt_reg   <= 3'd0;
                        unique case (job.kind)
                            ttlt_pkg::KIND_PASS:
                            begin
                                res_r_reg <= job.red;
                                res_g_reg <= job.green;
                                res_b_reg <= job.blue;
                                state_reg <= ST_DONE;
                            end
                            ttlt_pkg::KIND_FLAT:
                            begin
                                res_r_reg <= palette.midtone[23:16];
                                res_g_reg <= palette.midtone[15:8];
                                res_b_reg <= palette.midtone[7:0];
                                state_reg <= ST_DONE;
                            end
                            ttlt_pkg::KIND_RAMP:
                                state_reg <= ST_DIV;
                            default:
                                state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_DIV:
                begin
                    rem_reg   <= rem_next;
                    quo_reg   <= {quo_reg[6:0], qbit};
                    numlo_reg <= {numlo_reg[6:0], 1'b0};
                    cnt_reg   <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7)
                        state_reg <= ST_BLEND;
                end
                ST_BLEND:
                begin
                    sum_r_reg <= mix_sum(lo_col[23:16], hi_col[23:16], amt);
                    sum_g_reg <= mix_sum(lo_col[15:8], hi_col[15:8], amt);
                    sum_b_reg <= mix_sum(lo_col[7:0], hi_col[7:0], amt);
                    state_reg <= ST_NORM;
                end
                ST_NORM:
                begin
                    res_r_reg <= div255(sum_r_reg);
                    res_g_reg <= div255(sum_g_reg);
                    res_b_reg <= div255(sum_b_reg);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_alpha_reg <= job_reg.alpha;
                        out_red_reg   <= res_r_reg;
                        out_green_reg <= res_g_reg;
                        out_blue_reg  <= res_b_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/three_tone_luma_tint.sv]
// Three-tone luma tint: two-pass gradient map on straight ARGB pixels.
// Input channel (in_valid/in_stall): one word per pixel with a mode field.
//   Measure words fold pixel luma into a running min/max, clear words reset
//   those statistics, tint words produce one result each.
// Output channel (out_valid/out_stall): one tinted pixel per tint word, in
//   order. Measure and clear words produce nothing.
// Colors are set through the APB port: highlight at 0x0, midtone at 0x4,
//   shadow at 0x8; write them only while no tint word is in flight.
// Path from accept to result: front stages A, B and C, the queue, then the back
//   sequencer; ramp pixels add a restoring divide, a blend and a normalize step.
// Throughput: the front takes one word per cycle while in_stall is low; measure
//   and clear words sustain that. The back sequencer takes a new tint word only
//   once the last one is done; a 4-entry queue between them absorbs bursts, and
//   in_stall rises when a tint word meets a full queue.
// When out_stall is high the result word holds; the back can finish one more
//   job behind it before it waits.
// Reset clears the statistics, empties the queue, drops out_valid and loads
//   the default palette (white, mid grey, black).
`default_nettype none

module three_tone_luma_tint #(
    parameter int QUEUE_DEPTH = ttlt_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  in_alpha,
    input  wire logic [7:0]  in_red,
    input  wire logic [7:0]  in_green,
    input  wire logic [7:0]  in_blue,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_alpha,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ttlt_pkg::palette_t      palette_reg;
    ttlt_pkg::job_t          push_job, pop_job;
    ttlt_pkg::queue_status_t q_status;
    logic                    push, pop;
    logic                    cfg_write;
    logic [1:0]              reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Hold the color registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_reg.highlight <= ttlt_pkg::HIGHLIGHT_RESET;
            palette_reg.midtone   <= ttlt_pkg::MIDTONE_RESET;
            palette_reg.shadow    <= ttlt_pkg::SHADOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                ttlt_pkg::REG_HIGHLIGHT: palette_reg.highlight <= pwdata[23:0];
                ttlt_pkg::REG_MIDTONE:   palette_reg.midtone   <= pwdata[23:0];
                ttlt_pkg::REG_SHADOW:    palette_reg.shadow    <= pwdata[23:0];
                default:                 ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_index)
            ttlt_pkg::REG_HIGHLIGHT: prdata = {8'd0, palette_reg.highlight};
            ttlt_pkg::REG_MIDTONE:   prdata = {8'd0, palette_reg.midtone};
            ttlt_pkg::REG_SHADOW:    prdata = {8'd0, palette_reg.shadow};
            default:                 prdata = 32'd0;
        endcase
    end

    ttlt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .in_alpha (in_alpha),
        .in_red   (in_red),
        .in_green (in_green),
        .in_blue  (in_blue),
        .q_full   (q_status.full),
        .push     (push),
        .job      (push_job)
    );

    ttlt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    ttlt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .palette   (palette_reg),
        .q_empty   (q_status.empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_alpha (out_alpha),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule

`default_nettype wire

[rtl/ttlt_checker.sv]
`default_nettype none

module ttlt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  mode,
    input wire logic [7:0]  in_alpha,
    input wire logic [7:0]  in_red,
    input wire logic [7:0]  in_green,
    input wire logic [7:0]  in_blue,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  out_alpha,
    input wire logic [7:0]  out_red,
    input wire logic [7:0]  out_green,
    input wire logic [7:0]  out_blue,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [3:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled result word stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_alpha) && $stable(out_red)
                                   && $stable(out_green) && $stable(out_blue))
        else $error("result payload changed while stalled");

    // Reset drops the result channel, and the port never inserts wait states
    a_reset_idle: assert property (@(posedge clk)
        (!rst_n |=> !out_valid) and pready)
        else $error("result valid during reset or pready low");

    // A written color reads back on the next cycle
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(psel && penable && pwrite && pready)
        && psel && !pwrite && (paddr == $past(paddr)) && (paddr[3:2] != 2'd3)
        |-> prdata == {8'd0, $past(pwdata[23:0])})
        else $error("color register readback mismatch");

endmodule

bind three_tone_luma_tint ttlt_checker u_checker (.*);

`default_nettype wire
